### sv/snr_rs_pkg.sv
// Shared types and constants for the SNR table rate selector.
// No dependencies; imported by the controller, datapath and top level.
package snr_rs_pkg;

	localparam int RI_W  = 4;   // rate index width
	localparam int SNR_W = 16;  // signed Q8.8 dB
	localparam int CFG_IDX_W = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_RATE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE = 1'b1;

	// controller -> datapath commands
	typedef struct packed {
		logic start;  // load an in-range item, write the table, arm the scan
		logic bad;    // latch an out-of-range item
		logic scan;   // advance the table scan
		logic load;   // move the selection into the output register
	} dp_cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic in_ok;  // presented rate index lies in the usable range
		logic stop;   // scan reached an unmeasured entry or the last entry
	} dp_stat_t;

endpackage

### sv/snr_rs_ctrl.sv
// Controller state machine for the SNR table rate selector.
// Depends on snr_rs_pkg for the command and status structs.
module snr_rs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  snr_rs_pkg::dp_stat_t stat,
	output snr_rs_pkg::dp_cmd_t  cmd
);
	import snr_rs_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	// decode commands from state and handshakes
	always_comb begin
		cmd       = '0;
		cmd.start = (state_q == ST_IDLE) && in_valid && stat.in_ok;
		cmd.bad   = (state_q == ST_IDLE) && in_valid && !stat.in_ok;
		cmd.scan  = (state_q == ST_SCAN);
		cmd.load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// hold state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						state_q <= ST_SCAN;
					end else if (cmd.bad) begin
						state_q <= ST_DONE;
					end
				end
				ST_SCAN: begin
					if (stat.stop) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (cmd.load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### sv/snr_rs_dp.sv
// Datapath for the SNR table rate selector: config registers, SNR table
// memory with per-entry valid bits, scan compare and output registers.
// Depends on snr_rs_pkg.
module snr_rs_dp #(
	parameter int NUM_RATES = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [snr_rs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [snr_rs_pkg::RI_W-1:0]         cfg_data,
	input  logic [snr_rs_pkg::RI_W-1:0]         rate_index,
	input  logic signed [snr_rs_pkg::SNR_W-1:0] snr_db,
	input  snr_rs_pkg::dp_cmd_t                 cmd,
	output snr_rs_pkg::dp_stat_t                stat,
	output logic [snr_rs_pkg::RI_W-1:0]         best_rate_index,
	output logic                                rate_changed,
	output logic                                bad_index
);
	import snr_rs_pkg::*;

	localparam int AW   = (NUM_RATES > 1) ? $clog2(NUM_RATES) : 1;
	localparam int LAST = NUM_RATES - 1;

	logic [RI_W-1:0]         min_q, max_q;
	logic [RI_W-1:0]         hi_eff;
	logic signed [SNR_W-1:0] mem [NUM_RATES];
	logic [NUM_RATES-1:0]    valid_q;
	logic [RI_W-1:0]         scan_q, hi_q;
	logic                    issue_q;
	logic signed [SNR_W-1:0] rd_s1;
	logic                    vbit_s1, v_s1, last_s1;
	logic [RI_W-1:0]         idx_s1;
	logic signed [SNR_W-1:0] entry, top_q;
	logic [RI_W-1:0]         best_q, last_q;
	logic                    last_vld_q, bad_q;
	logic                    is_zero;

	// clamp the scan top to the table
	assign hi_eff = (32'(max_q) > LAST) ? RI_W'(LAST) : max_q;

	assign stat.in_ok = (rate_index >= min_q) && (rate_index <= max_q)
		&& (32'(rate_index) < NUM_RATES);

	// entry under evaluation; never-written entries read as zero
	assign entry     = vbit_s1 ? rd_s1 : '0;
	assign is_zero   = (entry == '0);
	assign stat.stop = cmd.scan && v_s1 && (is_zero || last_s1);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= RI_W'(0);
			max_q <= RI_W'(7);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_RATE: min_q <= cfg_data;
				REG_MAX_RATE: max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// table memory: write on start, registered read during scan
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mem[AW'(rate_index)] <= snr_db;
		end
		if (cmd.scan && issue_q) begin
			rd_s1 <= mem[AW'(scan_q)];
		end
	end

	// per-entry measured bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.start) begin
			valid_q[AW'(rate_index)] <= 1'b1;
		end
	end

	// scan control and read-stage tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			v_s1    <= 1'b0;
		end else begin
			if (cmd.start) begin
				issue_q <= 1'b1;
			end else if (cmd.scan && issue_q && (scan_q == hi_q)) begin
				issue_q <= 1'b0;
			end
			v_s1 <= cmd.scan && issue_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			scan_q <= min_q;
			hi_q   <= hi_eff;
		end else if (cmd.scan && issue_q) begin
			scan_q  <= scan_q + RI_W'(1);
			idx_s1  <= scan_q;
			last_s1 <= (scan_q == hi_q);
			vbit_s1 <= valid_q[AW'(scan_q)];
		end
	end

	// running winner; an unmeasured entry wins outright
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			best_q <= rate_index;
			top_q  <= snr_db;
		end else if (cmd.scan && v_s1) begin
			if (is_zero) begin
				best_q <= idx_s1;
			end else if (entry > top_q) begin
				best_q <= idx_s1;
				top_q  <= entry;
			end
		end
	end

	// item kind and previous selection
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bad_q      <= 1'b0;
			last_q     <= '0;
			last_vld_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				bad_q <= 1'b0;
			end else if (cmd.bad) begin
				bad_q <= 1'b1;
			end
			if (cmd.load && !bad_q) begin
				last_q     <= best_q;
				last_vld_q <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bad_index <= bad_q;
			if (bad_q) begin
				best_rate_index <= last_q;
				rate_changed    <= 1'b0;
			end else begin
				best_rate_index <= best_q;
				rate_changed    <= !last_vld_q || (best_q != last_q);
			end
		end
	end

endmodule

### sv/snr_table_rate_selector.sv
// SNR table rate selector: stores each measured SNR per rate index and
// picks the rate for the next transmission by scanning the table.
// Scan: an in-range item starts a scan from min_rate_index up to
//   min(max_rate_index, NUM_RATES-1), cut short when an entry reads zero
//   (unmeasured); the one-port table memory reads one entry per cycle. An
//   out-of-range item skips the scan.
// One item at a time; the next item is accepted the cycle after the result
//   is loaded. Reset clears the table valid bits, the last selection and the
//   configuration (min 0, max 7) at once; no clearing pass.
module snr_table_rate_selector #(
	parameter int NUM_RATES = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [snr_rs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [snr_rs_pkg::RI_W-1:0]         cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [snr_rs_pkg::RI_W-1:0]         rate_index,
	input  logic signed [snr_rs_pkg::SNR_W-1:0] snr_db,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [snr_rs_pkg::RI_W-1:0]         best_rate_index,
	output logic                                rate_changed,
	output logic                                bad_index
);
	import snr_rs_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	snr_rs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	snr_rs_dp #(
		.NUM_RATES (NUM_RATES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.rate_index      (rate_index),
		.snr_db          (snr_db),
		.cmd             (cmd),
		.stat            (stat),
		.best_rate_index (best_rate_index),
		.rate_changed    (rate_changed),
		.bad_index       (bad_index)
	);

	// at most one command per cycle
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.start, cmd.bad, cmd.scan, cmd.load}))
		else $error("controller issued overlapping commands");

	// an accepted item blocks the input until its result is loaded
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while an item is in flight");

	// a rejected index never reports a change
	a_bad_nochange: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_index |-> !rate_changed)
		else $error("out-of-range item reported a rate change");

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// Testbench for snr_table_rate_selector: directed and random SNR reports
// over several rate ranges, checked against an in-bench rate predictor.
// Depends on snr_rs_pkg and the snr_table_rate_selector top level.
module tb_top;
	import snr_rs_pkg::*;

	localparam int NUM_RATES = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = NUM_RATES + 8;
	localparam int LONG_HOLD = 400;

	typedef struct {
		logic [RI_W-1:0]         rate;
		logic signed [SNR_W-1:0] snr;
	} meas_t;

	typedef struct {
		logic [RI_W-1:0] best;
		logic            changed;
		logic            bad;
	} sel_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_MIN_RATE;
	logic [RI_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [RI_W-1:0] rate_index = '0;
	logic signed [SNR_W-1:0] snr_db = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [RI_W-1:0] best_rate_index;
	logic rate_changed;
	logic bad_index;

	// handshakes seen at the last rising edge
	logic in_fire = 1'b0;
	logic out_fire = 1'b0;
	logic cfg_fire = 1'b0;

	meas_t pending_meas[$];
	sel_result_t expected_sel[$];
	int meas_sent = 0;
	int meas_taken = 0;
	int results_seen = 0;
	int fail_count = 0;
	int cycle_count = 0;
	int in_idle_max = 8;
	int out_idle_max = 8;
	int in_gap = 0;
	int out_wait = 0;

	// predictor state
	logic signed [SNR_W-1:0] snr_store [NUM_RATES] = '{default: '0};
	logic [RI_W-1:0] prev_choice = '0;
	logic prev_valid = 1'b0;
	logic [RI_W-1:0] lo_cfg = 4'd0;
	logic [RI_W-1:0] hi_cfg = 4'd7;

	snr_table_rate_selector #(.NUM_RATES(NUM_RATES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rate_index(rate_index),
		.snr_db(snr_db),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.best_rate_index(best_rate_index),
		.rate_changed(rate_changed),
		.bad_index(bad_index)
	);

	always #2 clk = ~clk;

	// Store the new SNR, scan the usable range and return the selection.
	function automatic sel_result_t predict_selection(logic [RI_W-1:0] ri,
			logic signed [SNR_W-1:0] snr);
		sel_result_t r;
		logic signed [SNR_W-1:0] top;
		logic [RI_W-1:0] best;
		logic found;
		int scan_hi;
		scan_hi = (hi_cfg > NUM_RATES - 1) ? NUM_RATES - 1 : hi_cfg;
		if (ri < lo_cfg || ri > hi_cfg || ri >= NUM_RATES) begin
			r.best = prev_choice;
			r.changed = 1'b0;
			r.bad = 1'b1;
			return r;
		end
		snr_store[ri] = snr;
		best = ri;
		top = snr;
		found = 1'b0;
		for (int i = lo_cfg; i <= scan_hi; i++) begin
			if (!found) begin
				// an unmeasured entry is explored at once
				if (snr_store[i] == 0) begin
					best = RI_W'(i);
					found = 1'b1;
				end else if (snr_store[i] > top) begin
					best = RI_W'(i);
					top = snr_store[i];
				end
			end
		end
		r.best = best;
		r.changed = !prev_valid || (best != prev_choice);
		r.bad = 1'b0;
		prev_choice = best;
		prev_valid = 1'b1;
		return r;
	endfunction

	// Offer queued items, holding each until accepted, with random gaps.
	always @(negedge clk) begin : drive_meas
		meas_t m;
		if (!in_valid || in_fire) begin
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (pending_meas.size() != 0) begin
				m = pending_meas.pop_front();
				rate_index <= m.rate;
				snr_db <= m.snr;
				in_valid <= 1'b1;
				in_gap = $urandom_range(0, in_idle_max);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Stall the result side at random; hold off long twice to back up the input.
	always @(negedge clk) begin
		if (out_fire) begin
			out_wait = $urandom_range(0, out_idle_max);
			if (results_seen == 300 || results_seen == 1000)
				out_wait = LONG_HOLD;
		end else if (out_wait > 0) begin
			out_wait--;
		end
		out_ready <= (out_wait == 0);
	end

	// Track config writes, predict accepted items, check accepted results.
	always @(posedge clk) begin : watch_ports
		sel_result_t exp_sel;
		in_fire <= in_valid && in_ready;
		out_fire <= out_valid && out_ready;
		cfg_fire <= cfg_valid && cfg_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_MIN_RATE)
					lo_cfg = cfg_data;
				else if (cfg_index == REG_MAX_RATE)
					hi_cfg = cfg_data;
			end
			if (in_valid && in_ready) begin
				expected_sel.push_back(predict_selection(rate_index, snr_db));
				meas_taken++;
			end
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_sel.size() == 0) begin
					$error("unexpected result: best_rate_index %0d", best_rate_index);
					fail_count++;
				end else begin
					exp_sel = expected_sel.pop_front();
					if (best_rate_index !== exp_sel.best) begin
						$error("best_rate_index: expected %0d, got %0d",
							exp_sel.best, best_rate_index);
						fail_count++;
					end
					if (rate_changed !== exp_sel.changed) begin
						$error("rate_changed: expected %0d, got %0d",
							exp_sel.changed, rate_changed);
						fail_count++;
					end
					if (bad_index !== exp_sel.bad) begin
						$error("bad_index: expected %0d, got %0d",
							exp_sel.bad, bad_index);
						fail_count++;
					end
				end
			end
		end
	end

	// Stop a hung run.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_top: errors");
		$finish;
	end

	task automatic push_meas(input logic [RI_W-1:0] r, input logic [SNR_W-1:0] s);
		meas_t m;
		m.rate = r;
		m.snr = s;
		pending_meas.push_back(m);
		meas_sent++;
	endtask

	// Wait until every queued item is taken and every result is back.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (!(meas_taken == meas_sent && expected_sel.size() == 0));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RI_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(negedge clk);
		while (!cfg_fire);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_range(input logic [RI_W-1:0] lo, input logic [RI_W-1:0] hi);
		wait_idle();
		write_reg(REG_MIN_RATE, lo);
		write_reg(REG_MAX_RATE, hi);
	endtask

	initial begin : stimulus
		int lo_list [10];
		int hi_list [10];
		int lo;
		int hi;
		int r;
		logic [SNR_W-1:0] s;
		lo_list = '{0, 0, 3, 9, 15, 0, 2, 5, 0, 0};
		hi_list = '{7, 15, 5, 4, 15, 0, 12, 9, 0, 0};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset range, exploration, extremes, zero SNR, ties, out of range
		push_meas(4'd3, 16'h0100);
		push_meas(4'd0, 16'h7FFF);
		push_meas(4'd1, 16'h8000);
		push_meas(4'd2, 16'h0000);
		push_meas(4'd8, 16'h0100);
		push_meas(4'd15, 16'hFFFF);
		push_meas(4'd2, 16'h0200);
		push_meas(4'd3, 16'h0200);
		push_meas(4'd4, 16'h0200);
		push_meas(4'd5, 16'h0300);
		push_meas(4'd6, 16'hFF00);
		push_meas(4'd7, 16'h0001);
		push_meas(4'd5, 16'h0300);
		push_meas(4'd1, 16'h7FFF);
		// narrow range: below the minimum and above the maximum
		set_range(4'd3, 4'd5);
		push_meas(4'd2, 16'h0400);
		push_meas(4'd6, 16'h0400);
		push_meas(4'd4, 16'h0500);
		// minimum above maximum
		set_range(4'd9, 4'd4);
		push_meas(4'd9, 16'h0001);
		push_meas(4'd4, 16'h0001);
		// full table and single-entry ranges at both ends
		set_range(4'd0, 4'd15);
		push_meas(4'd15, 16'h7FFF);
		push_meas(4'd10, 16'h8000);
		set_range(4'd15, 4'd15);
		push_meas(4'd15, 16'h1234);
		set_range(4'd0, 4'd0);
		push_meas(4'd0, 16'h8000);
		push_meas(4'd1, 16'h0100);

		// random phases over fixed and drawn ranges
		for (int p = 0; p < 10; p++) begin
			if (p >= 8) begin
				lo = $urandom_range(0, 15);
				hi = $urandom_range(0, 15);
			end else begin
				lo = lo_list[p];
				hi = hi_list[p];
			end
			set_range(RI_W'(lo), RI_W'(hi));
			case (p % 4)
				0: begin in_idle_max = 8; out_idle_max = 8; end
				1: begin in_idle_max = 0; out_idle_max = 0; end
				2: begin in_idle_max = 0; out_idle_max = 8; end
				default: begin in_idle_max = 8; out_idle_max = 0; end
			endcase
			repeat (140) begin
				// mostly in range, some anywhere
				if (lo <= hi && $urandom_range(0, 99) < 85)
					r = $urandom_range(lo, hi);
				else
					r = $urandom_range(0, 15);
				case ($urandom_range(0, 9))
					0: s = 16'h0000;
					1: s = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
					2: s = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0001;
					3, 4, 5: s = {8'($urandom_range(0, 3) - 2), 8'h00};  // few levels, many ties
					default: s = SNR_W'($urandom);
				endcase
				push_meas(RI_W'(r), s);
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
